/* rtl/core/tod_pkg.sv */
// shared constants, types and helpers for the time-of-day string parser
`timescale 1ns / 1ps

package tod_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  localparam logic [3:0] POS_MAX   = 4'd12;
  localparam logic [3:0] LEN_HM    = 4'd5;
  localparam logic [3:0] LEN_HMS   = 4'd8;
  localparam logic [3:0] LEN_HMSM  = 4'd12;

  localparam logic [6:0] MAX_HOUR   = 7'd23;
  localparam logic [6:0] MAX_MINSEC = 7'd59;
  localparam logic [9:0] MAX_MILLI  = 10'd999;

  typedef struct packed {
    logic       valid_res;
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic [5:0] second_value;
    logic [9:0] milli_value;
  } tod_result_t;

  // value * 10 + digit, kept to 10 bits
  function automatic logic [9:0] mul10_add(input logic [9:0] value, input logic [3:0] digit);
    logic [9:0] times8;
    logic [9:0] times2;
    begin
      times8 = {value[6:0], 3'b000};
      times2 = {value[8:0], 1'b0};
      mul10_add = times8 + times2 + {6'd0, digit};
    end
  endfunction

endpackage

/* rtl/core/tod_parse.sv */
// parser state and per-character decode with end-of-string check
`timescale 1ns / 1ps

module tod_parse import tod_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  char_code,
  input  logic        last,
  output tod_result_t res
);

  logic [3:0] pos_r, pos_nxt, pos_upd;
  logic       err_r, err_nxt, err_upd;
  logic       term_r, term_nxt, term_upd;
  logic [6:0] hour_r, hour_nxt, hour_upd;
  logic [6:0] min_r, min_nxt, min_upd;
  logic [6:0] sec_r, sec_nxt, sec_upd;
  logic [9:0] milli_r, milli_nxt, milli_upd;
  logic       is_dig;
  logic [3:0] digit;
  logic [9:0] hour_x10, min_x10, sec_x10, milli_x10;
  logic       len_ok;
  logic       ok;

  assign is_dig    = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign digit     = 4'(char_code - CHAR_ZERO);
  assign hour_x10  = mul10_add({3'd0, hour_r}, digit);
  assign min_x10   = mul10_add({3'd0, min_r}, digit);
  assign sec_x10   = mul10_add({3'd0, sec_r}, digit);
  assign milli_x10 = mul10_add(milli_r, digit);

  always_comb begin
    pos_upd   = pos_r;
    err_upd   = err_r;
    term_upd  = term_r;
    hour_upd  = hour_r;
    min_upd   = min_r;
    sec_upd   = sec_r;
    milli_upd = milli_r;
    if (!term_r) begin
      if (char_code == CHAR_NUL) begin
        term_upd = 1'b1;
      end else begin
        unique case (pos_r)
          4'd0, 4'd1: begin
            if (is_dig) hour_upd = hour_x10[6:0];
            else err_upd = 1'b1;
          end
          4'd3, 4'd4: begin
            if (is_dig) min_upd = min_x10[6:0];
            else err_upd = 1'b1;
          end
          4'd6, 4'd7: begin
            if (is_dig) sec_upd = sec_x10[6:0];
            else err_upd = 1'b1;
          end
          4'd9, 4'd10, 4'd11: begin
            if (is_dig) milli_upd = milli_x10;
            else err_upd = 1'b1;
          end
          4'd2, 4'd5: begin
            if (char_code != CHAR_COLON) err_upd = 1'b1;
          end
          4'd8: begin
            if (char_code != CHAR_DOT) err_upd = 1'b1;
          end
          default: begin
            err_upd = 1'b1;
          end
        endcase
        if (pos_r < POS_MAX) pos_upd = pos_r + 4'd1;
      end
    end
  end

  assign len_ok = (pos_upd == LEN_HM) || (pos_upd == LEN_HMS) || (pos_upd == LEN_HMSM);
  assign ok = !err_upd && len_ok && (hour_upd <= MAX_HOUR) && (min_upd <= MAX_MINSEC)
           && (sec_upd <= MAX_MINSEC) && (milli_upd <= MAX_MILLI);

  always_comb begin
    res.valid_res    = ok;
    res.hour_value   = ok ? hour_upd[4:0] : 5'd0;
    res.minute_value = ok ? min_upd[5:0]  : 6'd0;
    res.second_value = ok ? sec_upd[5:0]  : 6'd0;
    res.milli_value  = ok ? milli_upd     : 10'd0;
  end

  // a string end clears everything for the next string
  always_comb begin
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    term_nxt  = term_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    milli_nxt = milli_r;
    if (step) begin
      if (last) begin
        pos_nxt   = 4'd0;
        err_nxt   = 1'b0;
        term_nxt  = 1'b0;
        hour_nxt  = 7'd0;
        min_nxt   = 7'd0;
        sec_nxt   = 7'd0;
        milli_nxt = 10'd0;
      end else begin
        pos_nxt   = pos_upd;
        err_nxt   = err_upd;
        term_nxt  = term_upd;
        hour_nxt  = hour_upd;
        min_nxt   = min_upd;
        sec_nxt   = sec_upd;
        milli_nxt = milli_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 4'd0;
      err_r   <= 1'b0;
      term_r  <= 1'b0;
      hour_r  <= 7'd0;
      min_r   <= 7'd0;
      sec_r   <= 7'd0;
      milli_r <= 10'd0;
    end else begin
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
      term_r  <= term_nxt;
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      milli_r <= milli_nxt;
    end
  end

endmodule

/* rtl/core/time_of_day_string_parser.sv */
// top level: time string parser with registered input and result stages
//
// usage:
//   in_*  : one ascii character per transaction, in_tlast marks the final
//           character of a string; a zero byte ends the string early and the
//           characters after it up to in_tlast are dropped
//   out_* : one result per string, sent for the in_tlast transaction only;
//           out_tuser is the valid flag, out_tdata holds hour, minute,
//           second and millisecond (all zero when the string is not valid)
//   accepted forms are HH:MM, HH:MM:SS and HH:MM:SS.mmm
// path: a string's final character is held in the input register, then its result
//   goes into the result register once that is free, which raises out_tvalid
// throughput: one character per cycle while no final character waits behind a held
//   result, set by the single decode stage between the input and result registers
// reset: clears both stages and the parser state; a string in progress is lost
// stall: while out_tready is low a pending result holds; the input register
//   still takes characters that make no result, and in_tready drops only when
//   a final character is waiting behind a held result
`timescale 1ns / 1ps

module time_of_day_string_parser import tod_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [4:0] hour_value, [10:5] minute_value,
                                  // [16:11] second_value, [26:17] milli_value, rest zero
  output logic [0:0]  out_tuser   // [0] valid_res
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  logic        out_valid_r, out_valid_nxt;
  tod_result_t out_res_r;
  tod_result_t res;
  logic        out_free;
  logic        step;
  logic        in_take;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || step;
  assign in_take   = in_tvalid && in_tready;

  tod_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .char_code (s1_char_r),
    .last      (s1_last_r),
    .res       (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (step) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && s1_last_r) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (step && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.valid_res;
  assign out_tdata  = {5'd0, out_res_r.milli_value, out_res_r.second_value,
                       out_res_r.minute_value, out_res_r.hour_value};

endmodule

/* sim/tod_parse_checker.sv */
// checker for the time string parser: predicts each string's result and compares it
`timescale 1ns / 1ps

module tod_parse_checker import tod_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [4:0] hour, [10:5] minute, [16:11] second,
                                  // [26:17] milli, rest zero
  input  logic [0:0]  out_tuser,  // [0] valid_res
  output int          mismatch_count,
  output int          results_pending
);

  // parser state as the stream has built it so far
  logic [3:0]  char_pos;
  logic        bad_format;
  logic        saw_nul;
  logic [6:0]  hour_acc;
  logic [6:0]  minute_acc;
  logic [6:0]  second_acc;
  logic [9:0]  milli_acc;

  tod_result_t expected_times[$];

  task automatic clear_string();
    char_pos   = '0;
    bad_format = 1'b0;
    saw_nul    = 1'b0;
    hour_acc   = '0;
    minute_acc = '0;
    second_acc = '0;
    milli_acc  = '0;
  endtask

  task automatic take_char(input logic [7:0] c);
    logic       is_dig;
    logic [3:0] d;
    is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d = 4'(c - CHAR_ZERO);
    case (char_pos)
      4'd0, 4'd1: begin
        if (is_dig) hour_acc = 7'(hour_acc * 10 + d);
        else bad_format = 1'b1;
      end
      4'd3, 4'd4: begin
        if (is_dig) minute_acc = 7'(minute_acc * 10 + d);
        else bad_format = 1'b1;
      end
      4'd6, 4'd7: begin
        if (is_dig) second_acc = 7'(second_acc * 10 + d);
        else bad_format = 1'b1;
      end
      4'd9, 4'd10, 4'd11: begin
        if (is_dig) milli_acc = 10'(milli_acc * 10 + d);
        else bad_format = 1'b1;
      end
      4'd2, 4'd5: begin
        if (c != CHAR_COLON) bad_format = 1'b1;
      end
      4'd8: begin
        if (c != CHAR_DOT) bad_format = 1'b1;
      end
      default: bad_format = 1'b1;
    endcase
    if (char_pos < POS_MAX) char_pos = char_pos + 4'd1;
  endtask

  function automatic tod_result_t string_result();
    tod_result_t r;
    logic        ok;
    ok = !bad_format
      && (char_pos == LEN_HM || char_pos == LEN_HMS || char_pos == LEN_HMSM)
      && hour_acc <= MAX_HOUR && minute_acc <= MAX_MINSEC
      && second_acc <= MAX_MINSEC && milli_acc <= MAX_MILLI;
    r = '0;
    if (ok) begin
      r.valid_res    = 1'b1;
      r.hour_value   = hour_acc[4:0];
      r.minute_value = minute_acc[5:0];
      r.second_value = second_acc[5:0];
      r.milli_value  = milli_acc;
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    tod_result_t exp_r;
    tod_result_t got_r;
    if (!rst_n) begin
      clear_string();
      expected_times.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        // a zero byte ends the string, whatever follows up to tlast is dropped
        if (!saw_nul) begin
          if (in_tdata == CHAR_NUL) saw_nul = 1'b1;
          else take_char(in_tdata);
        end
        if (in_tlast) begin
          expected_times.push_back(string_result());
          clear_string();
        end
      end
      if (out_tvalid && out_tready) begin
        got_r.valid_res    = out_tuser[0];
        got_r.hour_value   = out_tdata[4:0];
        got_r.minute_value = out_tdata[10:5];
        got_r.second_value = out_tdata[16:11];
        got_r.milli_value  = out_tdata[26:17];
        if (expected_times.size() == 0) begin
          note_failure($sformatf("unexpected result at %0t: valid=%0d %0d:%0d:%0d.%0d",
            $realtime, got_r.valid_res, got_r.hour_value, got_r.minute_value,
            got_r.second_value, got_r.milli_value));
        end else begin
          exp_r = expected_times.pop_front();
          if (got_r != exp_r || out_tdata[31:27] != 5'd0) begin
            note_failure($sformatf(
              "mismatch at %0t: expected valid=%0d %0d:%0d:%0d.%0d, got valid=%0d %0d:%0d:%0d.%0d pad=%h",
              $realtime, exp_r.valid_res, exp_r.hour_value, exp_r.minute_value,
              exp_r.second_value, exp_r.milli_value, got_r.valid_res, got_r.hour_value,
              got_r.minute_value, got_r.second_value, got_r.milli_value, out_tdata[31:27]));
          end
        end
      end
    end
    results_pending = expected_times.size();
  end

endmodule

/* sim/time_of_day_string_parser_tb.sv */
// testbench top for the time string parser: character stimulus, result stalls, verdict
`timescale 1ns / 1ps

module time_of_day_string_parser_tb import tod_pkg::*;;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG_HOLD} rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] char_code
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [4:0] hour, [10:5] minute, [16:11] second,
                                    // [26:17] milli, rest zero
  logic [0:0]  out_tuser;           // [0] valid_res

  int mismatch_count;
  int results_pending;

  int         burst_left = 0;
  int         chars_sent = 0;
  logic [7:0] str_buf[$];

  rx_mode_t rx_mode     = RX_ALWAYS;
  int       rx_mode_left = 0;
  int       rx_hold_left = 0;
  logic     rx_hold_ready = 1'b0;

  time_of_day_string_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tod_parse_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // receiver stall pattern, switching between modes at random
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(3, 0));
      rx_mode_left = $urandom_range(300, 40);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_ALWAYS:   out_tready <= 1'b1;
      RX_RANDOM:   out_tready <= ($urandom_range(1, 0) == 1);
      RX_PERIODIC: out_tready <= (rx_mode_left % 4 != 0);
      default: begin
        if (rx_hold_left == 0) begin
          rx_hold_left  = $urandom_range(24, 1);
          rx_hold_ready = ~rx_hold_ready;
        end else begin
          rx_hold_left--;
        end
        out_tready <= rx_hold_ready;
      end
    endcase
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_char(input logic [7:0] c, input logic l);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9, 0) == 0) ? 200 : $urandom_range(24, 1);
      if ($urandom_range(3, 0) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(8, 1)) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_buf();
    logic past_nul;
    past_nul = 1'b0;
    for (int i = 0; i < str_buf.size(); i++) begin
      send_char(str_buf[i], i == str_buf.size() - 1);
      if (!past_nul) chars_sent++;
      if (str_buf[i] == CHAR_NUL) past_nul = 1'b1;
    end
    str_buf.delete();
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  task automatic put_digits(input int v, input int n);
    int div;
    div = (n == 3) ? 100 : 10;
    for (int i = 0; i < n; i++) begin
      str_buf.push_back(8'(CHAR_ZERO + (v / div) % 10));
      div = div / 10;
    end
  endtask

  // mostly in range, sometimes anything the digits allow
  function automatic int pick_field(input int max_ok, input int span);
    if ($urandom_range(3, 0) != 0) return $urandom_range(max_ok, 0);
    return $urandom_range(span - 1, 0);
  endfunction

  task automatic random_string();
    int form;
    int idx;
    int n;
    if ($urandom_range(7, 0) == 0) begin
      // noise: any bytes, any length up to past the longest form
      n = $urandom_range(16, 1);
      repeat (n) str_buf.push_back(8'($urandom_range(255, 0)));
    end else begin
      form = $urandom_range(2, 0);
      put_digits(pick_field(23, 100), 2);
      str_buf.push_back(CHAR_COLON);
      put_digits(pick_field(59, 100), 2);
      if (form > 0) begin
        str_buf.push_back(CHAR_COLON);
        put_digits(pick_field(59, 100), 2);
      end
      if (form > 1) begin
        str_buf.push_back(CHAR_DOT);
        put_digits(pick_field(999, 1000), 3);
      end
      if ($urandom_range(3, 0) == 0) begin
        idx = $urandom_range(str_buf.size() - 1, 0);
        case ($urandom_range(3, 0))
          0: str_buf[idx] = 8'($urandom_range(255, 0));
          1: void'(str_buf.pop_back());
          2: repeat ($urandom_range(4, 1)) str_buf.push_back(8'($urandom_range(255, 0)));
          default: begin
            case ($urandom_range(2, 0))
              0: str_buf[idx] = CHAR_COLON;
              1: str_buf[idx] = CHAR_DOT;
              default: str_buf[idx] = 8'(CHAR_ZERO + $urandom_range(9, 0));
            endcase
          end
        endcase
      end
    end
    // early zero byte, with or without dropped characters behind it
    if ($urandom_range(7, 0) == 0) begin
      str_buf.push_back(CHAR_NUL);
      repeat ($urandom_range(3, 0)) str_buf.push_back(8'($urandom_range(255, 0)));
    end
    send_buf();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    put_text("23:59:59.999");
    send_buf();
    put_text("00:00");
    send_buf();
    // empty string: a lone zero byte with tlast
    str_buf.push_back(CHAR_NUL);
    send_buf();
    put_text("09:3");
    str_buf.push_back(CHAR_NUL);
    str_buf.push_back(8'hFF);
    send_buf();

    while (chars_sent < 650) random_string();
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    wait (results_pending == 0);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
rtl/core/tod_pkg.sv
rtl/core/tod_parse.sv
rtl/core/time_of_day_string_parser.sv
sim/tod_parse_checker.sv
sim/time_of_day_string_parser_tb.sv
